FILE: hw/rtl/mwtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtg_pkg
// Shared types and constants of the multi-waveform tone generator.
// ----------------------------------------------------------------------------
package mwtg_pkg;

    // Waveform select codes; code 7 has no member and plays as silence.
    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SAWTOOTH = 3'd3,
        WAVE_NOISE    = 3'd4,
        WAVE_DC       = 3'd5,
        WAVE_SILENCE  = 3'd6
    } wave_mode_t;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_MODE       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE_LEVEL = 2'd2;

    localparam int AMP_BITS  = 15;
    localparam int STEP_BITS = 32;

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 32'd0;
    localparam logic [AMP_BITS-1:0]  AMPLITUDE_RESET  = 15'd16384;

    // Noise source: right-shift Galois LFSR
    localparam int          LFSR_BITS  = 32;
    localparam logic [31:0] NOISE_MASK = 32'h8020_0003;
    localparam logic [31:0] NOISE_SEED = 32'h0000_ACE1;

    // 0.8 in Q15 for the right channel
    localparam logic [15:0] RIGHT_GAIN_Q15 = 16'd26214;

    typedef struct packed {
        wave_mode_t             wave_mode;
        logic [STEP_BITS-1:0]   phase_step;
        logic [AMP_BITS-1:0]    amplitude_level;
    } cfg_t;

endpackage

FILE: hw/rtl/mwtg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtg_cfg_regs
// Write-only configuration registers: mode, phase step, amplitude.
// ----------------------------------------------------------------------------
module mwtg_cfg_regs
    import mwtg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_WAVE_MODE:       cfg_next.wave_mode = wave_mode_t'(cfg_data[2:0]);
                REG_PHASE_STEP:      cfg_next.phase_step = cfg_data[STEP_BITS-1:0];
                REG_AMPLITUDE_LEVEL: cfg_next.amplitude_level = cfg_data[AMP_BITS-1:0];
                default:             cfg_next = cfg_reg;  // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_mode       <= WAVE_SILENCE;
            cfg_reg.phase_step      <= PHASE_STEP_RESET;
            cfg_reg.amplitude_level <= AMPLITUDE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/mwtg_osc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtg_osc
// Phase accumulator and noise LFSR, advanced once per accepted transaction (the LFSR only in noise mode).
// ----------------------------------------------------------------------------
module mwtg_osc
    import mwtg_pkg::*;
#(
    parameter int PHASE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  restart,
    input  cfg_t                  cfg,
    output logic [PHASE_BITS-1:0] phase_cur,
    output logic [LFSR_BITS-1:0]  noise_word
);

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [LFSR_BITS-1:0]  lfsr_reg;
    logic [LFSR_BITS-1:0]  lfsr_next;
    logic [LFSR_BITS-1:0]  lfsr_step;

    // phase used by this sample: restart zeroes it first
    assign phase_cur = restart ? '0 : phase_reg;

    assign lfsr_step  = {1'b0, lfsr_reg[LFSR_BITS-1:1]} ^ (lfsr_reg[0] ? NOISE_MASK : '0);
    assign noise_word = lfsr_step;

    always_comb
    begin
        phase_next = phase_reg;
        lfsr_next  = lfsr_reg;
        if (take)
        begin
            phase_next = phase_cur + PHASE_BITS'(cfg.phase_step);
            if (cfg.wave_mode == WAVE_NOISE)
            begin
                lfsr_next = lfsr_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            lfsr_reg  <= NOISE_SEED;
        end
        else
        begin
            phase_reg <= phase_next;
            lfsr_reg  <= lfsr_next;
        end
    end

endmodule

FILE: hw/rtl/mwtg_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwtg_sine_rom
// Quarter-wave sine magnitude table with registered read.
// ----------------------------------------------------------------------------
module mwtg_sine_rom #(
    parameter int DEPTH_LOG2 = 10,
    parameter int MAG_BITS   = 15
)
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [DEPTH_LOG2-1:0] rd_addr,
    output logic [MAG_BITS-1:0]   rd_data
);

    localparam int          ENTRIES     = 1 << DEPTH_LOG2;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] PEAK        = (64'd1 << MAG_BITS) - 64'd1;
    localparam logic [63:0] TaylorDiv [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

    // round(PEAK * sin(pi/2 * i / ENTRIES)), Q30 Taylor series to x^15
    function automatic logic [63:0] sine_entry(input logic [63:0] idx);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (idx * HALF_PI_Q30) >> DEPTH_LOG2;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / TaylorDiv[k];
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        v = (sum * PEAK + (64'd1 << 29)) >> 30;
        if (v > PEAK)
            v = PEAK;
        return v;
    endfunction

    logic [MAG_BITS-1:0] rom_tab [ENTRIES];
    logic [MAG_BITS-1:0] rd_data_reg;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_tab
        assign rom_tab[g] = MAG_BITS'(sine_entry(64'(g)));
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_tab[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/multi_waveform_tone_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_tone_generator
// DDS function generator: one stereo sample pair per input transaction.
//
// Input channel (in_valid/in_ready, restart_phase): each transaction is one
// sample tick. restart_phase zeroes the phase before that sample is made.
// Output channel (out_valid/out_ready, left_sample, right_sample): one
// transaction per input transaction, in order. right = left * 0.8 (Q15).
// Config port: cfg_write with cfg_index 0 mode, 1 phase step, 2 amplitude;
// other indexes are dropped. Write only while no sample is in flight.
// Pipeline: one register per stage (sine table read, wave shaping and
// amplitude multiply, right-channel multiply); out_valid rises once the
// accepted transaction has reached the output register. Throughput: one
// sample per cycle while out_ready is high; every stage holds one transaction.
// Stall: each stage advances when the one after it is empty or moving, so
// empty stages keep filling while the output waits; in_ready drops only
// when all three stages are full and out_ready is low.
// Reset: pipeline empty, phase 0, LFSR 0xACE1, mode silence, step 0,
// amplitude 0.5. The sine table is constant; no fill time after reset.
// ----------------------------------------------------------------------------
module multi_waveform_tone_generator
    import mwtg_pkg::*;
#(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    // input ticks
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart_phase,
    // output samples
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_sample,
    output logic signed [SAMPLE_BITS-1:0] right_sample
);

    localparam int S       = SAMPLE_BITS;
    // largest power of two not above the requested depth
    localparam int SIN_LG  = $clog2(SINE_TABLE_DEPTH + 1) - 1;

    localparam logic signed [S-1:0] PEAK_W = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0] MIN_W  = {1'b1, {(S-1){1'b0}}};

    cfg_t cfg;

    // ------------------------------------------------------------------
    // Handshake: per-stage enables, bubbles collapse
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic in_accept;

    assign s3_en     = !out_valid_reg || out_ready;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign in_ready  = s1_en;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and oscillator state
    // ------------------------------------------------------------------
    mwtg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic [PHASE_BITS-1:0] phase_cur;
    logic [LFSR_BITS-1:0]  noise_word;

    mwtg_osc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_osc (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_accept),
        .restart    (restart_phase),
        .cfg        (cfg),
        .phase_cur  (phase_cur),
        .noise_word (noise_word)
    );

    // ------------------------------------------------------------------
    // Stage 1: phase decode, sine table read
    // ------------------------------------------------------------------
    // phase padded with zeros so short accumulators still give top bits
    logic [PHASE_BITS+SIN_LG+1:0] sine_ext;
    logic [PHASE_BITS+S:0]        wave_ext;
    logic [SIN_LG+1:0]            sine_top;
    logic [SIN_LG-1:0]            sine_idx;
    logic [SIN_LG-1:0]            sine_addr;
    logic                         force_peak;

    assign sine_ext   = {phase_cur, {(SIN_LG+2){1'b0}}};
    assign wave_ext   = {phase_cur, {(S+1){1'b0}}};
    assign sine_top   = sine_ext[PHASE_BITS+SIN_LG+1:PHASE_BITS];
    assign sine_idx   = sine_top[SIN_LG-1:0];
    // odd quadrants read mirrored; their index zero is the peak itself
    assign sine_addr  = sine_top[SIN_LG] ? (~sine_idx + 1'b1) : sine_idx;
    assign force_peak = sine_top[SIN_LG] && (sine_idx == '0);

    logic [S-2:0] rom_mag;

    mwtg_sine_rom #(
        .DEPTH_LOG2 (SIN_LG),
        .MAG_BITS   (S-1)
    ) u_rom (
        .clk     (clk),
        .rd_en   (s1_en),
        .rd_addr (sine_addr),
        .rd_data (rom_mag)
    );

    logic [S:0]   s1_top_reg;     // top S+1 phase bits
    logic         s1_neg_reg;     // sine lower half
    logic         s1_peak_reg;
    logic [S-1:0] s1_noise_reg;

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_top_reg   <= wave_ext[PHASE_BITS+S:PHASE_BITS];
            s1_neg_reg   <= sine_top[SIN_LG+1];
            s1_peak_reg  <= force_peak;
            s1_noise_reg <= noise_word[LFSR_BITS-1 -: S];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: wave shaping and amplitude multiply
    // ------------------------------------------------------------------
    logic signed [S-1:0] sine_mag;
    logic signed [S-1:0] tri_rise;
    logic signed [S-1:0] tri_fall;
    logic signed [S-1:0] wave_val;
    logic signed [S+15:0] amp_prod;
    logic signed [S-1:0] left_mid_reg;
    logic signed [S-1:0] left_mid_next;

    assign sine_mag = s1_peak_reg ? PEAK_W : $signed({1'b0, rom_mag});
    // first half: f - half is f with its top bit inverted
    assign tri_rise = $signed({~s1_top_reg[S-1], s1_top_reg[S-2:0]});
    // second half: half - g, saturated where g is zero
    assign tri_fall = (s1_top_reg[S-1:0] == '0) ? PEAK_W : -tri_rise;

    always_comb
    begin
        case (cfg.wave_mode)
            WAVE_SINE:     wave_val = s1_neg_reg ? -sine_mag : sine_mag;
            WAVE_SQUARE:   wave_val = s1_top_reg[S] ? MIN_W : PEAK_W;
            WAVE_TRIANGLE: wave_val = s1_top_reg[S] ? tri_fall : tri_rise;
            WAVE_SAWTOOTH: wave_val = $signed(s1_top_reg[S:1]);
            WAVE_NOISE:    wave_val = $signed(s1_noise_reg);
            WAVE_DC:       wave_val = PEAK_W;
            default:       wave_val = '0;
        endcase
    end

    // arithmetic shift by 15 floors
    assign amp_prod      = wave_val * $signed({1'b0, cfg.amplitude_level});
    assign left_mid_next = amp_prod[S+14:15];

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            left_mid_reg <= left_mid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: right-channel gain, output register
    // ------------------------------------------------------------------
    logic signed [S+16:0] gain_prod;
    logic signed [S-1:0]  left_sample_reg;
    logic signed [S-1:0]  right_sample_reg;
    logic signed [S-1:0]  right_sample_next;

    assign gain_prod         = left_mid_reg * $signed({1'b0, RIGHT_GAIN_Q15});
    assign right_sample_next = gain_prod[S+14:15];

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            left_sample_reg  <= left_mid_reg;
            right_sample_reg <= right_sample_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = left_sample_reg;
    assign right_sample = right_sample_reg;

endmodule

FILE: test/tb_multi_waveform_tone_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_waveform_tone_generator
// Self-checking bench for the DDS tone generator. A behavioral copy of the
// phase accumulator, sine table, LFSR and Q15 gain chain predicts every
// stereo pair. Directed ticks cover each wave mode, the table quadrants and
// the field extremes. Random ticks then run under several sender and
// receiver idle patterns, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_multi_waveform_tone_generator
    import mwtg_pkg::*;
;

    localparam int SAMPLE_W     = 16;
    localparam int SINE_DEPTH   = 1024;
    localparam int PIPE_LATENCY = 3;
    localparam int DRAIN_LIMIT  = 5000;
    localparam longint TIMEOUT_NS = 2_000_000;

    // Full-scale sample levels and triangle midpoint
    localparam longint SAMPLE_PEAK = 32767;
    localparam longint SAMPLE_MIN  = -32768;
    localparam longint HALF_SCALE  = 32768;
    // pi/2 in Q30, seed for the Taylor series of the quarter-wave table
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [AMP_BITS-1:0]       AMP_FULL   = '1;
    // Index past the end of the register map; writes to it are dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } tone_pair_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic restart_phase = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    multi_waveform_tone_generator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart_phase (restart_phase),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_sample   (left_sample),
        .right_sample  (right_sample)
    );

    // ------------------------------------------------------------------------
    // Predictor state: own copy of the oscillator and its settings
    // ------------------------------------------------------------------------
    logic [15:0]          sine_rom [0:SINE_DEPTH-1];
    logic [31:0]          tone_phase;
    logic [LFSR_BITS-1:0] tone_lfsr;
    logic [2:0]           tone_mode;
    logic [STEP_BITS-1:0] tone_step;
    logic [AMP_BITS-1:0]  tone_amp;

    tone_pair_t expected_samples [$];

    // Bench knobs and statistics
    int send_idle_pct  = 0;     // chance per cycle that the sender holds off
    int recv_stall_pct = 0;     // chance per cycle that out_ready is low
    int hold_off_req   = 0;     // long output hold-off, picked up at negedge
    int error_count    = 0;
    int ticks_sent     = 0;
    int samples_checked = 0;
    int cfg_writes     = 0;
    int input_stall_cycles = 0;
    int mode_ticks [0:7] = '{default: 0};

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predict one tick. Phase used is the one before the advance; the LFSR
    // only steps in noise mode; restart clears the phase and nothing else.
    // ------------------------------------------------------------------------
    function automatic tone_pair_t predict_tick(input bit restart);
        tone_pair_t   pair;
        longint       w;
        longint       mag;
        longint       lft;
        longint       rgt;
        logic [11:0]  top;
        logic [9:0]   idx;
        logic [1:0]   quad;
        logic [16:0]  frac;
        logic         lsb;

        if (restart)
            tone_phase = '0;
        mode_ticks[tone_mode]++;
        case (tone_mode)
            WAVE_SINE: begin
                // 2 quadrant bits over a 10-bit table index
                top  = tone_phase[31:20];
                idx  = top[9:0];
                quad = top[11:10];
                if (quad[0])
                    mag = (idx == 0) ? SAMPLE_PEAK : longint'(sine_rom[10'd0 - idx]);
                else
                    mag = longint'(sine_rom[idx]);
                w = quad[1] ? -mag : mag;
            end
            WAVE_SQUARE:
                w = tone_phase[31] ? SAMPLE_MIN : SAMPLE_PEAK;
            WAVE_TRIANGLE: begin
                frac = tone_phase[31:15];
                if (!frac[16])
                    w = longint'(frac) - HALF_SCALE;
                else
                    w = 3 * HALF_SCALE - longint'(frac);
                if (w > SAMPLE_PEAK)
                    w = SAMPLE_PEAK;    // top of the ramp saturates
            end
            WAVE_SAWTOOTH:
                w = longint'($signed(tone_phase[31:16]));
            WAVE_NOISE: begin
                lsb = tone_lfsr[0];
                tone_lfsr = tone_lfsr >> 1;
                if (lsb)
                    tone_lfsr = tone_lfsr ^ NOISE_MASK;
                w = longint'($signed(tone_lfsr[31:16]));
            end
            WAVE_DC:
                w = SAMPLE_PEAK;
            default:
                w = 0;                  // silence and the unused code
        endcase
        // Arithmetic shifts give floor on both products
        lft = (w * longint'(tone_amp)) >>> 15;
        rgt = (lft * longint'(RIGHT_GAIN_Q15)) >>> 15;
        pair.left  = lft[SAMPLE_W-1:0];
        pair.right = rgt[SAMPLE_W-1:0];
        tone_phase = tone_phase + tone_step;
        return pair;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: random gaps, then hold valid until the transaction is taken.
    // Valid is left high on return so back-to-back ticks never toggle it.
    // ------------------------------------------------------------------------
    task automatic send_tick(input bit restart);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        restart_phase <= restart;
        @(posedge clk);
        while (!in_ready) begin
            input_stall_cycles++;
            @(posedge clk);
        end
        expected_samples.push_back(predict_tick(restart));
        ticks_sent++;
    endtask

    // Stop sending and wait for every predicted pair, then let the pipe settle
    task automatic wait_for_samples();
        int waited;

        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_samples.size() != 0) begin
            $error("%0d expected sample pairs never came out", expected_samples.size());
            error_count++;
            expected_samples.delete();
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // One register write; only called with the pipe empty
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_WAVE_MODE:       tone_mode = data[2:0];
            REG_PHASE_STEP:      tone_step = data[STEP_BITS-1:0];
            REG_AMPLITUDE_LEVEL: tone_amp  = data[AMP_BITS-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_BITS-1:0] mode_word,
                                  input logic [CFG_DATA_BITS-1:0] step,
                                  input logic [CFG_DATA_BITS-1:0] amp_word);
        wait_for_samples();
        write_reg(REG_WAVE_MODE, mode_word);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_AMPLITUDE_LEVEL, amp_word);
    endtask

    // Random mode, step and level, with extremes and junk upper bits mixed in
    task automatic randomize_settings();
        logic [CFG_DATA_BITS-1:0] mode_word;
        logic [CFG_DATA_BITS-1:0] step;
        logic [CFG_DATA_BITS-1:0] amp_word;

        mode_word = $urandom_range(0, 7);
        if ($urandom_range(1))
            mode_word = mode_word | ($urandom & ~32'h7);
        case ($urandom_range(5))
            0: step = '0;
            1: step = '1;
            2: step = $urandom;
            3: step = $urandom_range(1, 1 << 20);
            4: step = 32'h8000_0000 - $urandom_range(0, 255);
            default: step = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(3))
            0: amp_word = '0;
            1: amp_word = AMP_FULL;
            default: amp_word = $urandom;
        endcase
        apply_settings(mode_word, step, amp_word);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted here in cycles
    // ------------------------------------------------------------------------
    initial begin : out_ready_driver
        int hold_left;

        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req != 0) begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : sample_check
        tone_pair_t want;

        if (rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected output transaction: left_sample %0d right_sample %0d",
                       left_sample, right_sample);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (left_sample !== want.left) begin
                    $error("left_sample mismatch: expected %0d, actual %0d",
                           want.left, left_sample);
                    error_count++;
                end
                if (right_sample !== want.right) begin
                    $error("right_sample mismatch: expected %0d, actual %0d",
                           want.right, right_sample);
                    error_count++;
                end
                samples_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: silence, then DC at the default half-scale level.
    // A write to the unused index must not disturb anything.
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        wait_for_samples();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_WAVE_MODE, WAVE_DC);
        send_tick(1'b0);
    endtask

    // Quarter-turn steps land on every quadrant boundary, including the
    // mirrored index-zero reads that must return the peak
    task automatic test_sine_quadrants();
        apply_settings(WAVE_SINE, 32'h4000_0000, AMP_FULL);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
    endtask

    // Triangle at both ends (top end saturates), square both halves,
    // sawtooth at phase zero and at the last phase before the wrap
    task automatic test_wave_shapes();
        apply_settings(WAVE_TRIANGLE, 32'h8000_0000, AMP_FULL);
        send_tick(1'b1);
        send_tick(1'b0);
        apply_settings(WAVE_SQUARE, 32'h8000_0000, AMP_FULL);
        send_tick(1'b1);
        send_tick(1'b0);
        apply_settings(WAVE_SAWTOOTH, '1, AMP_FULL);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Noise keeps running across a restart; unused mode code and a level
    // that masks to zero both give silence
    task automatic test_noise_and_levels();
        apply_settings(WAVE_NOISE, 32'h1234_5678, AMP_FULL);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_for_samples();
        write_reg(REG_WAVE_MODE, '1);
        send_tick(1'b0);
        apply_settings(WAVE_DC, '0, 32'hFFFF_8000);
        send_tick(1'b0);
    endtask

    // Random ticks under each idle pattern, new settings every few dozen
    task automatic test_random_traffic();
        int send_pcts [0:3] = '{0, 87, 0, 30};
        int recv_pcts [0:3] = '{0, 0, 87, 30};

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            repeat (6) begin
                randomize_settings();
                repeat (48) send_tick($urandom_range(7) == 0);
            end
        end
    endtask

    // Output held off long enough for the pipe to fill and in_ready to drop,
    // then a full drain pause before the sender resumes
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        randomize_settings();
        @(posedge clk);
        hold_off_req = 60;
        repeat (24) send_tick($urandom_range(7) == 0);
        wait_for_samples();
        repeat (24) send_tick($urandom_range(7) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;

        // Quarter-wave table: Q30 Taylor series of sin, rounded to the peak
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x    = (longint'(i) * HALF_PI_Q30) / SINE_DEPTH;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
                term = ((((term * x) >> 30) * x) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            v = (sum * SAMPLE_PEAK + (64'd1 << 29)) >> 30;
            if (v > SAMPLE_PEAK)
                v = SAMPLE_PEAK;
            sine_rom[i] = v[15:0];
        end

        tone_phase = '0;
        tone_lfsr  = NOISE_SEED;
        tone_mode  = WAVE_SILENCE;
        tone_step  = PHASE_STEP_RESET;
        tone_amp   = AMPLITUDE_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_sine_quadrants();
        test_wave_shapes();
        test_noise_and_levels();
        test_random_traffic();
        test_output_backpressure();

        wait_for_samples();
        $display("Run: %0d ticks, %0d sample pairs checked, %0d register writes, %0d stall cycles",
                 ticks_sent, samples_checked, cfg_writes, input_stall_cycles);
        $display("Ticks per wave mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_ticks[0], mode_ticks[1], mode_ticks[2], mode_ticks[3],
                 mode_ticks[4], mode_ticks[5], mode_ticks[6], mode_ticks[7]);
        if (error_count == 0)
            $display("multi_waveform_tone_generator test passed");
        else
            $display("multi_waveform_tone_generator test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("multi_waveform_tone_generator test failed");
        $finish;
    end

endmodule
